@@ design/sha256_byte_stream_hasher_core_macros.svh @@
// assertion macros used by the hasher core
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// property checked at every clock edge outside reset
`define SHABS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked at every clock edge, reset included
`define SHABS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHABS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHABS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ design/shabs_pkg.sv @@
`timescale 1ns / 1ps

package shabs_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_COMP,
        S_FOLD,
        S_OUT
    } t_state;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic init;   // chain back to initial hash values
        logic load;   // working variables from chain
        logic step;   // one compression round
        logic fold;   // add working variables into chain
    } t_round_cmd;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // schedule sigma functions
    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // round sigma functions
    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

@@ design/shabs_sched.sv @@
`timescale 1ns / 1ps

module shabs_sched import shabs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_wr_en,
    input  logic [5:0]  i_wr_addr,
    input  logic [7:0]  i_wr_byte,
    input  logic        i_shift,
    output logic [31:0] o_w
);

    // sixteen-word window: block buffer while filling, schedule while compressing
    logic [31:0] r_w [16];
    logic [31:0] n_w_new;

    // next schedule word from the window taps
    always_comb begin
        n_w_new = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    end

    // byte writes big-endian within a word, shift one word per round
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= n_w_new;
        end else if (i_wr_en) begin
            r_w[i_wr_addr[5:2]][{~i_wr_addr[1:0], 3'b000} +: 8] <= i_wr_byte;
        end
    end

    assign o_w = r_w[0];

endmodule

@@ design/shabs_round.sv @@
`timescale 1ns / 1ps

module shabs_round import shabs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_round_cmd   i_cmd,
    input  logic [31:0]  i_w,
    input  logic [5:0]   i_round,
    output logic [255:0] o_digest
);

    // chain value and working variables a..h
    logic [31:0] r_h [8];
    logic [31:0] r_s [8];
    logic [31:0] n_t1;
    logic [31:0] n_t2;

    // round function
    always_comb begin
        n_t1 = r_s[7] + big_sigma1(r_s[4]) + ((r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]))
             + ROUND_K[i_round] + i_w;
        n_t2 = big_sigma0(r_s[0])
             + ((r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]));
    end

    // chain value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= INIT_H[i];
            end
        end else if (i_cmd.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_s[i];
            end
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 8; i++) begin
                r_s[i] <= r_h[i];
            end
        end else if (i_cmd.step) begin
            r_s[7] <= r_s[6];
            r_s[6] <= r_s[5];
            r_s[5] <= r_s[4];
            r_s[4] <= r_s[3] + n_t1;
            r_s[3] <= r_s[2];
            r_s[2] <= r_s[1];
            r_s[1] <= r_s[0];
            r_s[0] <= n_t1 + n_t2;
        end
    end

    // digest, word 0 most significant
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_digest[255 - 32 * i -: 32] = r_h[i];
        end
    end

endmodule

@@ design/sha256_byte_stream_hasher_core.sv @@
`timescale 1ns / 1ps
// channel  direction  handshake          payload
// input    in         i_valid / o_stall  i_data_byte[7:0], i_last_byte
// output   out        o_valid / i_stall  o_digest_part[63:0], o_part_index[1:0], o_last_part
//
// a byte is taken while the block is idle; the 64th byte of a block starts a compression:
// a load, 64 rounds of the shared round unit and a fold into the chain
// after the last byte, padding bytes are written one per cycle up to the block end and compressed,
// plus one extra padding block when fewer than 8 bytes remain after the pad mark
// four digest parts follow, one per cycle when the output side does not stall
// reset is synchronous, active low, and restores the initial hash values at once
// o_stall is high whenever the block is not waiting for a byte

`include "sha256_byte_stream_hasher_core_macros.svh"

module sha256_byte_stream_hasher_core import shabs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_part,
    output logic [1:0]  o_part_index,
    output logic        o_last_part
);

    t_state     r_state;
    t_state     n_state;
    logic [5:0] r_fill;
    logic [63:0] r_bits;
    logic [5:0] r_round;
    logic [1:0] r_part;
    logic       r_final;
    logic       r_put80;
    logic       r_len_here;

    logic       in_xact;
    logic       out_xact;
    logic       wr_en;
    logic       shift;
    logic [7:0] wr_byte;
    logic [7:0] pad_byte;
    t_round_cmd cmd;
    logic [31:0] w;
    logic [255:0] digest;

    assign in_xact  = i_valid && !o_stall;
    assign out_xact = o_valid && !i_stall;

    // padding byte: mark, then zeros, then big-endian bit length
    always_comb begin
        if (r_put80) begin
            pad_byte = PAD_MARK;
        end else if (r_len_here && (r_fill[5:3] == 3'b111)) begin
            pad_byte = r_bits[{~r_fill[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xact) begin
                    if (r_fill == 6'd63) begin
                        n_state = S_LOAD;
                    end else if (i_last_byte) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_fill == 6'd63) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_COMP;
            end
            S_COMP: begin
                if (r_round == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (!r_final) begin
                    n_state = S_IDLE;
                end else if (r_len_here) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (out_xact && (r_part == 2'd3)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall  = 1'b1;
        o_valid  = 1'b0;
        wr_en    = 1'b0;
        wr_byte  = pad_byte;
        shift    = 1'b0;
        cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                wr_en   = in_xact;
                wr_byte = i_data_byte;
            end
            S_PAD: begin
                wr_en = 1'b1;
            end
            S_LOAD: begin
                cmd.load = 1'b1;
            end
            S_COMP: begin
                cmd.step = 1'b1;
                shift    = 1'b1;
            end
            S_FOLD: begin
                cmd.fold = 1'b1;
            end
            S_OUT: begin
                o_valid  = 1'b1;
                cmd.init = out_xact && (r_part == 2'd3);
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // state, counters and padding flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_bits     <= '0;
            r_round    <= '0;
            r_part     <= '0;
            r_final    <= 1'b0;
            r_put80    <= 1'b0;
            r_len_here <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (in_xact) begin
                r_bits <= r_bits + 64'd8;
                if (i_last_byte) begin
                    r_final <= 1'b1;
                    r_put80 <= 1'b1;
                end
            end
            // the pad mark decides whether the length fits in this block
            if ((r_state == S_PAD) && r_put80) begin
                r_put80    <= 1'b0;
                r_len_here <= (r_fill[5:3] != 3'b111);
            end
            if ((r_state == S_FOLD) && r_final && !r_len_here) begin
                r_len_here <= 1'b1;
            end
            if (r_state == S_LOAD) begin
                r_round <= '0;
            end else if (r_state == S_COMP) begin
                r_round <= r_round + 6'd1;
            end
            if (out_xact) begin
                r_part <= r_part + 2'd1;
                if (r_part == 2'd3) begin
                    r_fill     <= '0;
                    r_bits     <= '0;
                    r_final    <= 1'b0;
                    r_put80    <= 1'b0;
                    r_len_here <= 1'b0;
                end
            end
        end
    end

    shabs_sched u_sched (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill),
        .i_wr_byte (wr_byte),
        .i_shift   (shift),
        .o_w       (w)
    );

    shabs_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_w      (w),
        .i_round  (r_round),
        .o_digest (digest)
    );

    // digest part select, most significant quarter first
    always_comb begin
        unique case (r_part)
            2'd0: o_digest_part = digest[255:192];
            2'd1: o_digest_part = digest[191:128];
            2'd2: o_digest_part = digest[127:64];
            2'd3: o_digest_part = digest[63:0];
            default: o_digest_part = digest[255:192];
        endcase
    end

    assign o_part_index = r_part;
    assign o_last_part  = (r_part == 2'd3);

    // checks
    `SHABS_ASSERT_ALWAYS(a_no_in_while_out, i_clk, o_valid |-> o_stall, "byte taken during digest output")
    `SHABS_ASSERT(a_last_blocks_in, i_clk, i_rst_n, (in_xact && i_last_byte) |=> o_stall, "last byte did not start padding")
    `SHABS_ASSERT(a_round_start, i_clk, i_rst_n, (r_state == S_LOAD) |=> (r_round == 6'd0), "round counter not cleared at compression start")
    `SHABS_ASSERT(a_clean_restart, i_clk, i_rst_n, (out_xact && o_last_part) |=> ((r_fill == 6'd0) && (r_bits == 64'd0) && !o_stall), "state not cleared after digest")

endmodule
